FILE: design/smcor_pkg.sv
// Shared constants and types for the square matrix corner-orient rotator.
package smcor_pkg;

  localparam int SIDE_BITS      = 7;
  localparam int SIDE_RESET     = 4;
  localparam int MAX_SIDE_DEF   = 64;
  localparam int VALUE_BITS_DEF = 31;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef enum logic [1:0] {
    ROT_IDENT = 2'd0,
    ROT_HALF  = 2'd1,
    ROT_CW    = 2'd2,
    ROT_CCW   = 2'd3
  } rot_e;

endpackage

FILE: design/square_matrix_corner_orient_rotate.sv
// Top level of the square matrix corner-orient rotator.
//
// Input channel (in_valid_i/in_ready_o) carries one transaction per item:
// operation_i selects a load (element_value_i written in row-major order) or
// an emit (next element of the rotated matrix). Loads give no result; each
// emit gives one result transaction on the output channel
// (out_valid_o/out_ready_i) with out_value_o, row_end_o, matrix_end_o and
// status_o. After the last load the largest corner is turned to the bottom
// right. An emit before the matrix is complete or after it has been read out
// returns status not_ready with all other fields zero.
// An accepted emit reads memory into the read stage at its accepting edge; the
// output register then raises out_valid_o. Throughput: one transaction per
// cycle while the receiver takes results; the single read stage between
// memory and output register sets this rate.
// When the receiver stalls, the read stage and output register fill and
// in_ready_o drops. cfg_we_i writes side_length and restarts loading and
// readout. Reset restores side 4 and empty control state; matrix memory
// contents are undefined until loaded (no clearing pass).
module square_matrix_corner_orient_rotate #(
  parameter int MAX_SIDE   = smcor_pkg::MAX_SIDE_DEF,
  parameter int VALUE_BITS = smcor_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [smcor_pkg::SIDE_BITS-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             operation_i,
  input  logic [VALUE_BITS-1:0]            element_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [VALUE_BITS-1:0]            out_value_o,
  output logic                             row_end_o,
  output logic                             matrix_end_o,
  output logic                             status_o
);
  import smcor_pkg::*;

  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int SW       = $clog2(MAX_SIDE + 1);
  localparam int CW       = $clog2(MAX_SIDE);
  localparam int LW       = $clog2(DEPTH + 1);
  localparam int AW       = $clog2(DEPTH);
  localparam int EW       = (SW > SIDE_BITS) ? SW : SIDE_BITS;
  localparam int RST_SIDE = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
  localparam int RST_TOT  = RST_SIDE * RST_SIDE;

  logic [VALUE_BITS-1:0] mem_q [DEPTH];
  logic [VALUE_BITS-1:0] rdata_q;

  logic [SW-1:0]         side_q;
  logic [CW-1:0]         last_q;
  logic [LW-1:0]         total_q;
  logic [LW-1:0]         lastrow_q;
  logic [LW-1:0]         load_cnt_q;
  logic [CW-1:0]         row_q, col_q;
  logic                  done_q;
  rot_e                  rot_q;
  logic [VALUE_BITS-1:0] corner_q [4];

  logic                  pend_q, pend_ok_q, pend_rend_q, pend_mend_q;
  logic                  out_valid_q, out_rend_q, out_mend_q, out_status_q;
  logic [VALUE_BITS-1:0] out_value_q;

  // configuration decode
  logic [EW-1:0] cfg_ext;
  logic [SW-1:0] side_d;
  logic [LW-1:0] total_d;

  always_comb begin
    cfg_ext = EW'(cfg_data_i);
    if (cfg_ext == '0) begin
      side_d = SW'(1);
    end else if (cfg_ext > EW'(MAX_SIDE)) begin
      side_d = SW'(MAX_SIDE);
    end else begin
      side_d = SW'(cfg_ext);
    end
    total_d = LW'(side_d) * LW'(side_d);
  end

  // item decode
  logic                  in_acc, move;
  logic [LW-1:0]         cnt_eff, cnt_inc;
  logic                  load_go, emit_acc, emit_ok;
  logic [VALUE_BITS-1:0] corner_d [4];
  rot_e                  rot_d;
  logic [CW-1:0]         sr, sc;
  logic [LW-1:0]         raddr_full;
  logic                  rend, mend;

  assign move       = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || move;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    cnt_eff  = done_q ? '0 : load_cnt_q;
    cnt_inc  = cnt_eff + LW'(1);
    load_go  = in_acc && (operation_i == OP_LOAD) && (cnt_eff != total_q);
    emit_acc = in_acc && (operation_i == OP_EMIT);
    emit_ok  = (load_cnt_q == total_q) && !done_q;

    for (int k = 0; k < 4; k++) begin
      corner_d[k] = corner_q[k];
    end
    if (cnt_eff == '0)                 corner_d[0] = element_value_i;
    if (cnt_eff == LW'(last_q))        corner_d[1] = element_value_i;
    if (cnt_eff == lastrow_q)          corner_d[2] = element_value_i;
    if (cnt_eff == total_q - LW'(1))   corner_d[3] = element_value_i;

    if (corner_d[0] >= corner_d[1] && corner_d[0] >= corner_d[2] &&
        corner_d[0] >= corner_d[3]) begin
      rot_d = ROT_HALF;
    end else if (corner_d[1] >= corner_d[2] && corner_d[1] >= corner_d[3]) begin
      rot_d = ROT_CW;
    end else if (corner_d[2] >= corner_d[3]) begin
      rot_d = ROT_CCW;
    end else begin
      rot_d = ROT_IDENT;
    end

    unique case (rot_q)
      ROT_HALF: begin
        sr = last_q - row_q;
        sc = last_q - col_q;
      end
      ROT_CW: begin
        sr = last_q - col_q;
        sc = row_q;
      end
      ROT_CCW: begin
        sr = col_q;
        sc = last_q - row_q;
      end
      default: begin
        sr = row_q;
        sc = col_q;
      end
    endcase
    raddr_full = LW'(sr) * LW'(side_q) + LW'(sc);
    rend       = (col_q == last_q);
    mend       = rend && (row_q == last_q);
  end

  // matrix memory
  always_ff @(posedge clk_i) begin
    if (load_go) begin
      mem_q[cnt_eff[AW-1:0]] <= element_value_i;
    end
    if (emit_acc && emit_ok) begin
      rdata_q <= mem_q[raddr_full[AW-1:0]];
    end
  end

  // corner capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        corner_q[k] <= '0;
      end
    end else if (load_go) begin
      for (int k = 0; k < 4; k++) begin
        corner_q[k] <= corner_d[k];
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q     <= SW'(RST_SIDE);
      last_q     <= CW'(RST_SIDE - 1);
      total_q    <= LW'(RST_TOT);
      lastrow_q  <= LW'(RST_TOT - RST_SIDE);
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      done_q     <= 1'b0;
      rot_q      <= ROT_IDENT;
    end else if (cfg_we_i) begin
      side_q     <= side_d;
      last_q     <= CW'(side_d - SW'(1));
      total_q    <= total_d;
      lastrow_q  <= total_d - LW'(side_d);
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      done_q     <= 1'b0;
    end else if (in_acc) begin
      if (operation_i == OP_LOAD) begin
        if (done_q) begin
          done_q <= 1'b0;
        end
        if (load_go) begin
          load_cnt_q <= cnt_inc;
          if (cnt_inc == total_q) begin
            rot_q <= rot_d;
          end
        end
      end else if (emit_ok) begin
        if (mend) begin
          done_q <= 1'b1;
          row_q  <= '0;
          col_q  <= '0;
        end else if (rend) begin
          row_q <= row_q + CW'(1);
          col_q <= '0;
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  // read stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= 1'b0;
      pend_ok_q    <= 1'b0;
      pend_rend_q  <= 1'b0;
      pend_mend_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_rend_q   <= 1'b0;
      out_mend_q   <= 1'b0;
      out_status_q <= STATUS_OK;
    end else begin
      if (move) begin
        out_valid_q  <= 1'b1;
        out_value_q  <= pend_ok_q ? rdata_q : '0;
        out_rend_q   <= pend_rend_q;
        out_mend_q   <= pend_mend_q;
        out_status_q <= pend_ok_q ? STATUS_OK : STATUS_NOT_READY;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit_acc) begin
        pend_q      <= 1'b1;
        pend_ok_q   <= emit_ok;
        pend_rend_q <= emit_ok && rend;
        pend_mend_q <= emit_ok && mend;
      end else if (move) begin
        pend_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign row_end_o    = out_rend_q;
  assign matrix_end_o = out_mend_q;
  assign status_o     = out_status_q;

  a_notready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_NOT_READY) |->
      (out_value_o == '0) && !row_end_o && !matrix_end_o)
    else $error("not_ready result carries data");

  a_mend_rend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && matrix_end_o |-> row_end_o)
    else $error("matrix end without row end");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q <= total_q)
    else $error("load count beyond matrix size");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= last_q) && (col_q <= last_q))
    else $error("read position outside matrix");

  a_mend_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_acc && emit_ok && mend && !cfg_we_i |=> done_q)
    else $error("readout not closed after last element");

endmodule

FILE: sim/tb_square_matrix_corner_orient_rotate.sv
// Self-checking testbench for the square matrix corner-orient rotator.
module tb_square_matrix_corner_orient_rotate;
  timeunit 1ns;
  timeprecision 1ps;

  import smcor_pkg::*;

  localparam int VB             = VALUE_BITS_DEF;
  localparam int MAX_N          = MAX_SIDE_DEF;
  localparam int RANDOM_ITEMS   = 280;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef logic [VB-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   row_end;
    logic   matrix_end;
    logic   status;
  } result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic                  op;
    value_t                val;
    logic [SIDE_BITS-1:0]  side;
    bit                    typed;
    result_t               res;
  } plan_row_t;

  localparam result_t NOT_READY_RES = '{31'h0, 1'b0, 1'b0, STATUS_NOT_READY};
  localparam result_t MAX_SINGLE    = '{31'h7FFFFFFF, 1'b1, 1'b1, STATUS_OK};
  localparam result_t ZERO_SINGLE   = '{31'h0, 1'b1, 1'b1, STATUS_OK};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [SIDE_BITS-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 operation_i;
  value_t               element_value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  value_t               out_value_o;
  logic                 row_end_o;
  logic                 matrix_end_o;
  logic                 status_o;

  // typed expectation travels with the transaction that owns it
  bit                   tb_typed;
  result_t              tb_typed_res;

  bit                   idle_on  = 1'b1;
  bit                   hold_req = 1'b0;
  int                   errors;
  int                   useful_items;
  int                   results_checked;
  int                   sides_written;
  int                   quiet_cycles;
  result_t              pending_results[$];
  plan_row_t            plan[$];

  // rotator mirror state
  value_t               mirror_mem [0:MAX_N*MAX_N-1];
  int unsigned          loaded_cnt;
  int unsigned          rd_row;
  int unsigned          rd_col;
  bit                   rd_done;
  logic [SIDE_BITS-1:0] side_reg = SIDE_BITS'(SIDE_RESET);
  value_t               corner [4] = '{default: '0};
  rot_e                 rot_mode = ROT_IDENT;
  int                   rot_seen [4];

  square_matrix_corner_orient_rotate dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_value_o     (out_value_o),
    .row_end_o       (row_end_o),
    .matrix_end_o    (matrix_end_o),
    .status_o        (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_side(input logic [SIDE_BITS-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_N) return MAX_N;
    return s;
  endfunction

  task automatic restart_mirror();
    loaded_cnt = 0;
    rd_row     = 0;
    rd_col     = 0;
    rd_done    = 1'b0;
  endtask

  task automatic mirror_step(input logic op, input value_t val, output bit has,
                             output result_t res);
    int unsigned n, total, last, r, c, sr, sc;
    value_t      mx;
    n     = eff_side(side_reg);
    total = n * n;
    last  = n - 1;
    has   = 1'b0;
    res   = '0;
    if (op == OP_LOAD) begin
      if (rd_done) restart_mirror();
      if (loaded_cnt < total) begin
        mirror_mem[loaded_cnt] = val;
        if (loaded_cnt == 0) corner[0] = val;
        if (loaded_cnt == last) corner[1] = val;
        if (loaded_cnt == last * n) corner[2] = val;
        if (loaded_cnt == total - 1) corner[3] = val;
        loaded_cnt++;
        if (loaded_cnt == total) begin
          mx = corner[0];
          for (int k = 1; k < 4; k++) if (corner[k] > mx) mx = corner[k];
          if (corner[0] == mx) rot_mode = ROT_HALF;
          else if (corner[1] == mx) rot_mode = ROT_CW;
          else if (corner[2] == mx) rot_mode = ROT_CCW;
          else rot_mode = ROT_IDENT;
          rot_seen[rot_mode]++;
        end
      end
    end else begin
      has = 1'b1;
      if (loaded_cnt < total || rd_done || rd_row >= n || rd_col >= n) begin
        res.status = STATUS_NOT_READY;
      end else begin
        r = rd_row;
        c = rd_col;
        case (rot_mode)
          ROT_HALF: begin sr = last - r; sc = last - c; end
          ROT_CW:   begin sr = last - c; sc = r;        end
          ROT_CCW:  begin sr = c;        sc = last - r; end
          default:  begin sr = r;        sc = c;        end
        endcase
        res.value      = mirror_mem[sr * n + sc];
        res.row_end    = (c == last);
        res.matrix_end = (c == last) && (r == last);
        res.status     = STATUS_OK;
        if (res.matrix_end) begin
          rd_done = 1'b1;
          rd_row  = 0;
          rd_col  = 0;
        end else if (res.row_end) begin
          rd_row = r + 1;
          rd_col = 0;
        end else begin
          rd_col = c + 1;
        end
      end
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    result_t want, got;
    bit      has;
    if (rst_ni) begin
      if (cfg_we_i) begin
        side_reg = cfg_data_i;
        restart_mirror();
      end
      if (in_valid_i && in_ready_o) begin
        mirror_step(operation_i, element_value_i, has, want);
        if (has) pending_results.push_back(tb_typed ? tb_typed_res : want);
      end
      if (out_valid_o && out_ready_i) begin
        got = '{out_value_o, row_end_o, matrix_end_o, status_o};
        if (pending_results.size() == 0) begin
          note_mismatch("result with nothing pending", 32'(got), '0);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.value !== want.value)
            note_mismatch("out_value", 32'(got.value), 32'(want.value));
          if (got.row_end !== want.row_end)
            note_mismatch("row_end", 32'(got.row_end), 32'(want.row_end));
          if (got.matrix_end !== want.matrix_end)
            note_mismatch("matrix_end", 32'(got.matrix_end), 32'(want.matrix_end));
          if (got.status !== want.status)
            note_mismatch("status", 32'(got.status), 32'(want.status));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("tb_square_matrix_corner_orient_rotate: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic op, input value_t val, input bit typed,
                           input result_t res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    element_value_i <= val;
    tb_typed        <= typed;
    tb_typed_res    <= res;
    do @(posedge clk_i); while (!in_ready_o);
    useful_items++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_side(input logic [SIDE_BITS-1:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sides_written++;
  endtask

  task automatic run_matrix(input logic [SIDE_BITS-1:0] side_val, input bit noisy,
                            input bit hold);
    int unsigned n, total, cut;
    bit          is_corner;
    value_t      v;
    write_side(side_val);
    n     = eff_side(side_val);
    total = n * n;
    cut   = total;
    if (noisy && $urandom_range(0, 5) == 0) cut = $urandom_range(0, total - 1);
    if (noisy && $urandom_range(0, 2) == 0)
      send_item(OP_EMIT, value_t'($urandom()), 1'b0, '0);
    for (int unsigned i = 0; i < cut; i++) begin
      is_corner = (i == 0) || (i == n - 1) || (i == (n - 1) * n) || (i == total - 1);
      case ($urandom_range(0, 7))
        0:       v = '0;
        1:       v = '1;
        2, 3:    v = is_corner ? value_t'($urandom_range(0, 3)) : value_t'($urandom());
        default: v = value_t'($urandom());
      endcase
      send_item(OP_LOAD, v, 1'b0, '0);
      if (noisy && $urandom_range(0, 19) == 0)
        send_item(OP_EMIT, value_t'($urandom()), 1'b0, '0);
    end
    if (cut < total) begin
      send_item(OP_EMIT, value_t'($urandom()), 1'b0, '0);
      return;
    end
    if (noisy && $urandom_range(0, 2) == 0) begin
      send_item(OP_LOAD, value_t'($urandom()), 1'b0, '0);
      useful_items--;  // full matrix, load dropped
    end
    if (hold) hold_req = 1'b1;
    cut = total;
    if (noisy && $urandom_range(0, 5) == 0) cut = $urandom_range(1, total);
    for (int unsigned i = 0; i < cut; i++)
      send_item(OP_EMIT, value_t'($urandom()), 1'b0, '0);
    if (noisy && cut == total && $urandom_range(0, 1) == 0) begin
      send_item(OP_EMIT, value_t'($urandom()), 1'b0, '0);
      send_item(OP_LOAD, value_t'($urandom()), 1'b0, '0);
      send_item(OP_EMIT, value_t'($urandom()), 1'b0, '0);
    end
  endtask

  initial begin
    int                   random_start;
    logic [SIDE_BITS-1:0] s;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    operation_i     <= OP_LOAD;
    element_value_i <= '0;
    tb_typed        <= 1'b0;
    tb_typed_res    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing loaded yet at reset side
    plan.push_back('{ROW_ITEM, OP_EMIT, 31'h0, 7'd0, 1'b1, NOT_READY_RES});
    plan.push_back('{ROW_CFG, OP_LOAD, 31'h0, 7'd2, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_EMIT, 31'h7FFFFFFF, 7'd0, 1'b1, NOT_READY_RES});
    // tl ties br at max: first match gives half turn
    plan.push_back('{ROW_ITEM, OP_LOAD, 31'h7FFFFFFF, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_LOAD, 31'h0, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_LOAD, 31'h2AAAAAAA, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_LOAD, 31'h7FFFFFFF, 7'd0, 1'b0, '0});
    // full, dropped
    plan.push_back('{ROW_ITEM, OP_LOAD, 31'h55555555, 7'd0, 1'b0, '0});
    for (int i = 0; i < 4; i++)
      plan.push_back('{ROW_ITEM, OP_EMIT, 31'h55555555, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_EMIT, 31'h0, 7'd0, 1'b1, NOT_READY_RES});
    // load after readout opens a new matrix, tr max
    plan.push_back('{ROW_ITEM, OP_LOAD, 31'd1, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_LOAD, 31'd9, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_LOAD, 31'd2, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_LOAD, 31'd3, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_EMIT, 31'h0, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_EMIT, 31'h0, 7'd0, 1'b0, '0});
    // side write in mid readout restarts
    plan.push_back('{ROW_CFG, OP_LOAD, 31'h0, 7'd1, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_LOAD, 31'h7FFFFFFF, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_EMIT, 31'h0, 7'd0, 1'b1, MAX_SINGLE});
    plan.push_back('{ROW_ITEM, OP_EMIT, 31'h0, 7'd0, 1'b1, NOT_READY_RES});
    // side zero acts as one
    plan.push_back('{ROW_CFG, OP_LOAD, 31'h0, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_LOAD, 31'h0, 7'd0, 1'b0, '0});
    plan.push_back('{ROW_ITEM, OP_EMIT, 31'h7FFFFFFF, 7'd0, 1'b1, ZERO_SINGLE});

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_side(plan[i].side);
      else send_item(plan[i].op, plan[i].val, plan[i].typed, plan[i].res);
    end

    random_start = useful_items;
    while (useful_items - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       s = 7'd0;
        1:       s = 7'd1;
        2:       s = 7'd4;
        3:       s = SIDE_BITS'($urandom_range(6, 8));
        default: s = SIDE_BITS'($urandom_range(2, 5));
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      run_matrix(s, $urandom_range(0, 2) != 0, 1'b0);
    end

    // receiver holds off at readout while emits keep coming
    idle_on = 1'b1;
    run_matrix(7'd4, 1'b0, 1'b1);

    // side above the limit acts as the largest side, so 70 loads leave it open
    write_side(7'd127);
    for (int i = 0; i < 70; i++) send_item(OP_LOAD, value_t'($urandom()), 1'b0, '0);
    send_item(OP_EMIT, value_t'($urandom()), 1'b0, '0);

    idle_on = 1'b0;
    run_matrix(7'd3, 1'b0, 1'b0);
    run_matrix(7'd2, 1'b0, 1'b0);

    drain();
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_mismatch("results never arrived", pending_results.size(), '0);

    $display("summary: %0d transactions in, %0d results checked, %0d side writes",
             useful_items, results_checked, sides_written);
    $display("summary: rotations identity %0d, half %0d, cw %0d, ccw %0d",
             rot_seen[ROT_IDENT], rot_seen[ROT_HALF], rot_seen[ROT_CW], rot_seen[ROT_CCW]);
    if (errors == 0) begin
      $display("tb_square_matrix_corner_orient_rotate: clean");
    end else begin
      $display("tb_square_matrix_corner_orient_rotate: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/smcor_pkg.sv
design/square_matrix_corner_orient_rotate.sv
sim/tb_square_matrix_corner_orient_rotate.sv
